// ===== rtl/core/pcdm_pkg.sv =====
`default_nettype none

package pcdm_pkg;

    // Field widths.
    localparam int unsigned TIME_W = 16;
    localparam int unsigned TICK_W = 11;
    localparam int unsigned DUTY_W = 7;

    // Duty full scale. The quotient is resolved over DUTY_W bits; anything at
    // or above 2**DUTY_W saturates at once.
    localparam logic [DUTY_W-1:0] DUTY_FULL_SCALE = 7'd100;
    localparam logic [TICK_W-1:0] DUTY_MULT       = 11'd100;

    // Width of high_ticks * 100 and of the aligned divisor.
    localparam int unsigned NUM_W  = TIME_W + DUTY_W;
    localparam int unsigned PROD_W = TIME_W + TICK_W;

    // Iteration counter for the quotient bits below the saturation check.
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'(DUTY_W - 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd0;

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_NUM  = 8'b0000_0010,
        ST_SAT  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_SCP  = 8'b0001_0000,
        ST_SCH  = 8'b0010_0000,
        ST_SCL  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } pcdm_state_t;

endpackage : pcdm_pkg

`default_nettype wire

// ===== rtl/core/pwm_capture_duty_meter_core.sv =====
// A rising-edge capture forms high*100 on the shared 16x11 multiplier, runs the
// saturation check and the divide steps, then 3 scaling multiplies and the
// output load; it skips the divide steps when the duty saturates early, and a
// falling-edge or zero-period capture goes straight to the scaling multiplies.
// Captures go one at a time; the next is taken the cycle after the output load.
// Reset (aresetn low, synchronous) clears control state; tick_reg returns to 1.
`default_nettype none

module pwm_capture_duty_meter_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [pcdm_pkg::TICK_W-1:0]   cfg_wr_data,
    // Capture input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pcdm_pkg::TIME_W-1:0]   s_capture_time,
    // Measurement output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_next_edge_rising,
    output logic                               m_measure_updated,
    output logic [pcdm_pkg::TIME_W-1:0]        m_period_ticks,
    output logic [pcdm_pkg::TIME_W-1:0]        m_high_ticks,
    output logic [pcdm_pkg::DUTY_W-1:0]        m_duty_percent,
    output logic                               m_zero_period,
    output logic [pcdm_pkg::TIME_W-1:0]        m_period_scaled,
    output logic [pcdm_pkg::TIME_W-1:0]        m_high_scaled,
    output logic [pcdm_pkg::TIME_W-1:0]        m_low_scaled
);
    import pcdm_pkg::*;

    pcdm_state_t         state_reg, state_next;

    logic                awaiting_falling_reg, awaiting_falling_next;
    logic [TIME_W-1:0]   rise_reg, rise_next;
    logic [TIME_W-1:0]   fall_reg, fall_next;
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [TIME_W-1:0]   high_reg, high_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                updated_reg, updated_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;

    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    div_reg, div_next;
    logic [DUTY_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [TIME_W-1:0]   pscl_reg, pscl_next;
    logic [TIME_W-1:0]   hscl_reg, hscl_next;
    logic [TIME_W-1:0]   lscl_reg, lscl_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_load;

    logic [TIME_W-1:0]   mul_a;
    logic [TICK_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_fits;
    logic [NUM_W-1:0]    div_diff;
    logic [DUTY_W-1:0]   quo_step;
    logic                in_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Shared multiplier: high*100 for the dividend, then the three scalings.
    always_comb begin
        mul_a = high_reg;
        mul_b = tick_reg;
        unique case (state_reg)
            ST_NUM:  begin mul_a = high_reg;              mul_b = DUTY_MULT; end
            ST_SCP:  begin mul_a = period_reg;            mul_b = tick_reg;  end
            ST_SCH:  begin mul_a = high_reg;              mul_b = tick_reg;  end
            ST_SCL:  begin mul_a = period_reg - high_reg; mul_b = tick_reg;  end
            default: begin mul_a = high_reg;              mul_b = tick_reg;  end
        endcase
    end
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Shared compare-subtract step of the restoring divider.
    assign div_fits = (rem_reg >= div_reg);
    assign div_diff = rem_reg - div_reg;
    assign quo_step = {quo_reg[DUTY_W-2:0], div_fits};

    // Sequencer and datapath.
    always_comb begin
        state_next            = state_reg;
        awaiting_falling_next = awaiting_falling_reg;
        rise_next             = rise_reg;
        fall_next             = fall_reg;
        period_next           = period_reg;
        high_next             = high_reg;
        duty_next             = duty_reg;
        updated_next          = updated_reg;
        rem_next              = rem_reg;
        div_next              = div_reg;
        quo_next              = quo_reg;
        step_next             = step_reg;
        pscl_next             = pscl_reg;
        hscl_next             = hscl_reg;
        lscl_next             = lscl_reg;
        tick_next             = cfg_wr_en ? cfg_wr_data : tick_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!awaiting_falling_reg) begin
                        // Rising edge closes the last pulse.
                        period_next           = s_capture_time - rise_reg;
                        high_next             = fall_reg - rise_reg;
                        rise_next             = s_capture_time;
                        awaiting_falling_next = 1'b1;
                        updated_next          = 1'b1;
                        if (s_capture_time == rise_reg) begin
                            duty_next  = '0;
                            state_next = ST_SCP;
                        end else begin
                            state_next = ST_NUM;
                        end
                    end else begin
                        fall_next             = s_capture_time;
                        awaiting_falling_next = 1'b0;
                        updated_next          = 1'b0;
                        state_next            = ST_SCP;
                    end
                end
            end
            ST_NUM: begin
                rem_next   = mul_prod[NUM_W-1:0];
                div_next   = {period_reg, {DUTY_W{1'b0}}};
                quo_next   = '0;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                // A quotient of 2**DUTY_W or more saturates without iterating.
                div_next  = div_reg >> 1;
                step_next = STEP_FIRST;
                if (div_fits) begin
                    duty_next  = DUTY_FULL_SCALE;
                    state_next = ST_SCP;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_fits) begin
                    rem_next = div_diff;
                end
                div_next  = div_reg >> 1;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_LAST) begin
                    duty_next  = (quo_step > DUTY_FULL_SCALE) ? DUTY_FULL_SCALE : quo_step;
                    state_next = ST_SCP;
                end
            end
            ST_SCP: begin
                pscl_next  = mul_prod[TIME_W-1:0];
                state_next = ST_SCH;
            end
            ST_SCH: begin
                hscl_next  = mul_prod[TIME_W-1:0];
                state_next = ST_SCL;
            end
            ST_SCL: begin
                lscl_next  = mul_prod[TIME_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and measurement state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            awaiting_falling_reg <= 1'b0;
            rise_reg             <= '0;
            fall_reg             <= '0;
            period_reg           <= '0;
            high_reg             <= '0;
            duty_reg             <= '0;
            updated_reg          <= 1'b0;
            tick_reg             <= TICK_W'(1);
            step_reg             <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            state_reg            <= state_next;
            awaiting_falling_reg <= awaiting_falling_next;
            rise_reg             <= rise_next;
            fall_reg             <= fall_next;
            period_reg           <= period_next;
            high_reg             <= high_next;
            duty_reg             <= duty_next;
            updated_reg          <= updated_next;
            tick_reg             <= tick_next;
            step_reg             <= step_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        pscl_reg <= pscl_next;
        hscl_reg <= hscl_next;
        lscl_reg <= lscl_next;
    end

    // Output register, loaded once the previous result has been taken.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_next_edge_rising <= !awaiting_falling_reg;
            m_measure_updated  <= updated_reg;
            m_period_ticks     <= period_reg;
            m_high_ticks       <= high_reg;
            m_duty_percent     <= duty_reg;
            m_zero_period      <= (period_reg == '0);
            m_period_scaled    <= pscl_reg;
            m_high_scaled      <= hscl_reg;
            m_low_scaled       <= lscl_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule : pwm_capture_duty_meter_core

`default_nettype wire

// ===== rtl/core/pcdm_checker.sv =====
`default_nettype none

module pcdm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [pcdm_pkg::TIME_W-1:0]   s_capture_time,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_next_edge_rising,
    input wire logic                          m_measure_updated,
    input wire logic [pcdm_pkg::TIME_W-1:0]   m_period_ticks,
    input wire logic [pcdm_pkg::DUTY_W-1:0]   m_duty_percent,
    input wire logic                          m_zero_period
);
    import pcdm_pkg::*;

    // A stalled capture holds until its transfer.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_capture_time))
        else $error("capture changed while stalled");

    // A stalled result keeps its duty and period until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duty_percent)
                                && $stable(m_period_ticks))
        else $error("result changed while stalled");

    // Duty never exceeds full scale.
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_duty_percent <= DUTY_FULL_SCALE)
        else $error("duty above full scale");

    // A zero period reports zero duty and a zero period count.
    a_zero_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_period |-> m_duty_percent == '0 && m_period_ticks == '0)
        else $error("zero period with nonzero duty or period");

    // A rising capture asks for a falling edge next, and the reverse.
    a_edge_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_measure_updated != m_next_edge_rising)
        else $error("edge order inconsistent with update flag");

endmodule : pcdm_checker

bind pwm_capture_duty_meter_core pcdm_checker u_pcdm_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_capture_time     (s_capture_time),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_next_edge_rising (m_next_edge_rising),
    .m_measure_updated  (m_measure_updated),
    .m_period_ticks     (m_period_ticks),
    .m_duty_percent     (m_duty_percent),
    .m_zero_period      (m_zero_period)
);

`default_nettype wire
